### src/hpe_pkg.sv
// Package with shared types and constants for the Horner polynomial evaluator.
package hpe_pkg;

  localparam int HPE_NUM_COEFFS = 8;
  localparam int HPE_REG_COUNT  = 8;
  localparam int HPE_IDX_W      = 3;
  localparam int HPE_COEF_W     = 16;
  localparam int HPE_ARG_W      = 16;
  localparam int HPE_ACC_W      = 64;
  localparam int HPE_PROD_W     = HPE_ACC_W + HPE_ARG_W;

  localparam logic [HPE_COEF_W-1:0] HPE_COEF_RESET [HPE_REG_COUNT] = '{
    16'hFFFB, 16'h0001, 16'hFFFE, 16'h0003,
    16'h0000, 16'h0000, 16'h0000, 16'h0000
  };

  typedef struct packed {
    logic [HPE_ARG_W-1:0] arg;
    logic [HPE_ACC_W-1:0] acc;
    logic                 ovf;
  } hpe_item_t;

endpackage

### src/hpe_cell.sv
// One Horner step cell: a multiply stage followed by a coefficient add stage.
module hpe_cell
  import hpe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [HPE_COEF_W-1:0] coef,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hpe_item_t             in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hpe_item_t             out_item
);

  logic                  mul_valid_r;
  logic [HPE_ARG_W-1:0]  mul_arg_r;
  logic [HPE_ACC_W-1:0]  mul_prod_r;
  logic                  mul_ovf_r;
  logic                  add_valid_r;
  hpe_item_t             add_item_r;

  logic                  mul_ready;
  logic                  add_ready;
  logic signed [HPE_PROD_W-1:0] prod_full;
  logic                  prod_ovf;
  logic [HPE_ACC_W-1:0]  coef_ext;
  logic [HPE_ACC_W-1:0]  sum;
  logic                  sum_ovf;

  assign add_ready = !add_valid_r || out_ready;
  assign mul_ready = !mul_valid_r || add_ready;
  assign in_ready  = mul_ready;

  assign prod_full = $signed(in_item.acc) * $signed(in_item.arg);
  assign prod_ovf  = prod_full[HPE_PROD_W-1:HPE_ACC_W-1] !=
                     {(HPE_ARG_W+1){prod_full[HPE_ACC_W-1]}};

  assign coef_ext = {{(HPE_ACC_W-HPE_COEF_W){coef[HPE_COEF_W-1]}}, coef};
  assign sum      = mul_prod_r + coef_ext;
  assign sum_ovf  = ~(mul_prod_r[HPE_ACC_W-1] ^ coef_ext[HPE_ACC_W-1]) &
                    (mul_prod_r[HPE_ACC_W-1] ^ sum[HPE_ACC_W-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_valid_r <= 1'b0;
    end else if (mul_ready) begin
      mul_valid_r <= in_valid;
    end
    if (mul_ready && in_valid) begin
      mul_arg_r  <= in_item.arg;
      mul_prod_r <= prod_full[HPE_ACC_W-1:0];
      mul_ovf_r  <= in_item.ovf | prod_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_valid_r <= 1'b0;
    end else if (add_ready) begin
      add_valid_r <= mul_valid_r;
    end
    if (add_ready && mul_valid_r) begin
      add_item_r.arg <= mul_arg_r;
      add_item_r.acc <= sum;
      add_item_r.ovf <= mul_ovf_r | sum_ovf;
    end
  end

  assign out_valid = add_valid_r;
  assign out_item  = add_item_r;

  // An overflow seen upstream must never be dropped by this cell.
  a_ovf_sticky_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_item.ovf) |=> mul_ovf_r)
    else $error("overflow flag lost in multiply stage");

  a_ovf_sticky_add: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_valid_r && add_ready && mul_ovf_r) |=> add_item_r.ovf)
    else $error("overflow flag lost in add stage");

  a_mul_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (mul_valid_r && !add_ready) |=> (mul_valid_r && $stable(mul_prod_r)))
    else $error("multiply stage changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (add_valid_r && !out_ready) |=> (add_valid_r && $stable(add_item_r)))
    else $error("result changed while stalled");

endmodule

### src/horner_polynomial_evaluator.sv
// Top level of the Horner polynomial evaluator: coefficient registers and a chain of step cells.
// Each cell holds a multiply register and an add register.
// Throughput is one request per cycle; each stage stalls only when the one after it is full.
// Reset is synchronous and active low; it empties the pipeline and loads the
// coefficients of 3x^3 - 2x^2 + x - 5.
module horner_polynomial_evaluator
  import hpe_pkg::*;
#(
  parameter int NUM_COEFFS = HPE_NUM_COEFFS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [HPE_IDX_W-1:0]  cfg_index,
  input  logic [HPE_COEF_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [15:0] argument
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [63:0]           out_tdata,  // [63:0] poly_value
  output logic                  out_tuser   // [0] overflow
);

  localparam int NUM_CELLS = NUM_COEFFS - 1;

  logic [HPE_COEF_W-1:0] coef_r [HPE_REG_COUNT];

  logic      chain_valid [NUM_CELLS+1];
  logic      chain_ready [NUM_CELLS+1];
  hpe_item_t chain_item  [NUM_CELLS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HPE_REG_COUNT; i++) begin
        coef_r[i] <= HPE_COEF_RESET[i];
      end
    end else if (cfg_we) begin
      coef_r[cfg_index] <= cfg_wdata;
    end
  end

  assign chain_valid[0]    = in_tvalid;
  assign in_tready         = chain_ready[0];
  assign chain_item[0].arg = in_tdata[HPE_ARG_W-1:0];
  assign chain_item[0].acc = {{(HPE_ACC_W-HPE_COEF_W){coef_r[NUM_COEFFS-1][HPE_COEF_W-1]}},
                              coef_r[NUM_COEFFS-1]};
  assign chain_item[0].ovf = 1'b0;

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    hpe_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .coef      (coef_r[NUM_COEFFS-2-k]),
      .in_valid  (chain_valid[k]),
      .in_ready  (chain_ready[k]),
      .in_item   (chain_item[k]),
      .out_valid (chain_valid[k+1]),
      .out_ready (chain_ready[k+1]),
      .out_item  (chain_item[k+1])
    );
  end

  assign chain_ready[NUM_CELLS] = out_tready;
  assign out_tvalid             = chain_valid[NUM_CELLS];
  assign out_tdata              = chain_item[NUM_CELLS].acc;
  assign out_tuser              = chain_item[NUM_CELLS].ovf;

endmodule

### test/tb_horner_polynomial_evaluator.sv
// Self-checking testbench for the Horner polynomial evaluator with its own polynomial predictor.
module tb_horner_polynomial_evaluator
  import hpe_pkg::*;
();

  localparam int LAT_CYC     = 2 * (HPE_NUM_COEFFS - 1);
  localparam int RAND_CHUNKS = 8;
  localparam int CHUNK_ITEMS = 200;
  localparam int SQUEEZE_LEN = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int N_DIR       = 26;

  localparam logic [15:0] EDGE_VALS [5] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF};

  typedef enum logic [1:0] {ROW_ARG, ROW_WRITE, ROW_FILL} row_kind_t;

  typedef struct {
    logic [63:0] value;
    logic        ovf;
  } poly_res_t;

  typedef struct {
    row_kind_t            kind;
    logic [HPE_IDX_W-1:0] idx;
    logic [15:0]          val;
    bit                   known;
    poly_res_t            res;
  } stim_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [HPE_IDX_W-1:0]  cfg_index  = '0;
  logic [HPE_COEF_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic [15:0]           in_tdata   = '0;
  logic                  out_tready = 1'b0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [63:0]           out_tdata;
  logic                  out_tuser;

  logic [15:0] coef_q [HPE_REG_COUNT];
  poly_res_t   pending_q [$];
  poly_res_t   want_r;
  stim_row_t   dir_tbl [N_DIR];
  int          mism_cnt    = 0;
  int          send_idle   = 34;
  int          recv_idle   = 86;
  int          cur_phase   = 0;
  int          squeeze_cnt = 0;
  int          stall_cnt   = 0;

  always #5 clk = ~clk;

  horner_polynomial_evaluator #(
    .NUM_COEFFS(HPE_NUM_COEFFS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  function automatic poly_res_t eval_poly(logic [15:0] arg);
    logic [63:0]  x;
    logic [63:0]  acc;
    logic [63:0]  term;
    logic [127:0] prod;
    logic [64:0]  sum;
    poly_res_t    r;
    x = {{48{arg[15]}}, arg};
    acc = {{48{coef_q[HPE_NUM_COEFFS-1][15]}}, coef_q[HPE_NUM_COEFFS-1]};
    r.ovf = 1'b0;
    for (int i = HPE_NUM_COEFFS - 2; i >= 0; i--) begin
      prod = {{64{acc[63]}}, acc} * {{64{x[63]}}, x};
      if (prod[127:63] != {65{prod[63]}}) r.ovf = 1'b1;
      acc = prod[63:0];
      term = {{48{coef_q[i][15]}}, coef_q[i]};
      sum = {acc[63], acc} + {term[63], term};
      if (sum[64] != sum[63]) r.ovf = 1'b1;
      acc = sum[63:0];
    end
    r.value = acc;
    return r;
  endfunction

  function automatic logic [15:0] rand_arg();
    int unsigned pick;
    int          sh;
    pick = $urandom_range(0, 9);
    sh = $urandom_range(0, 14);
    if (pick < 4) return 16'(int'($urandom_range(0, 300)) - 150);
    else if (pick < 8) return 16'($urandom());
    else if (pick == 8) return EDGE_VALS[$urandom_range(0, 4)];
    else if ($urandom_range(0, 1) == 0) return 16'(1 << sh);
    else return 16'(-(1 << sh));
  endfunction

  task automatic write_reg(input logic [HPE_IDX_W-1:0] idx, input logic [15:0] val);
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    coef_q[idx] = val;
  endtask

  task automatic send_arg(input logic [15:0] a, input poly_res_t res);
    cfg_we <= 1'b0;
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= a;
    do @(posedge clk); while (!in_tready);
    pending_q.push_back(res);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (cur_phase == 2 && squeeze_cnt < SQUEEZE_LEN) begin
      out_tready  <= 1'b0;
      squeeze_cnt <= squeeze_cnt + 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        if (mism_cnt < 10) begin
          $display("unexpected result: value %h overflow %b", out_tdata, out_tuser);
        end
        mism_cnt++;
      end else begin
        want_r = pending_q.pop_front();
        if (out_tdata !== want_r.value || out_tuser !== want_r.ovf) begin
          if (mism_cnt < 10) begin
            $display("mismatch: value exp %h got %h, overflow exp %b got %b",
                     want_r.value, out_tdata, want_r.ovf, out_tuser);
          end
          mism_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("tb_horner_polynomial_evaluator: FAIL");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    logic [15:0] arg_v;
    logic [15:0] new_c;
    int          mode;
    int          deg;
    dir_tbl = '{
      '{ROW_ARG,   3'd0, 16'h0000, 1'b1, '{-64'sd5, 1'b0}},
      '{ROW_ARG,   3'd0, 16'h0001, 1'b1, '{-64'sd3, 1'b0}},
      '{ROW_ARG,   3'd0, 16'hFFFF, 1'b1, '{-64'sd11, 1'b0}},
      '{ROW_ARG,   3'd0, 16'h0002, 1'b1, '{64'sd13, 1'b0}},
      '{ROW_ARG,   3'd0, 16'h7FFF, 1'b0, '{64'd0, 1'b0}},
      '{ROW_ARG,   3'd0, 16'h8000, 1'b0, '{64'd0, 1'b0}},
      '{ROW_ARG,   3'd0, 16'h5555, 1'b0, '{64'd0, 1'b0}},
      '{ROW_ARG,   3'd0, 16'hAAAA, 1'b0, '{64'd0, 1'b0}},
      '{ROW_FILL,  3'd0, 16'h7FFF, 1'b0, '{64'd0, 1'b0}},
      '{ROW_ARG,   3'd0, 16'h0000, 1'b1, '{64'sd32767, 1'b0}},
      '{ROW_ARG,   3'd0, 16'h0001, 1'b1, '{64'sd262136, 1'b0}},
      '{ROW_ARG,   3'd0, 16'hFFFF, 1'b1, '{64'sd0, 1'b0}},
      '{ROW_ARG,   3'd0, 16'h7FFF, 1'b0, '{64'd0, 1'b0}},
      '{ROW_ARG,   3'd0, 16'h8000, 1'b0, '{64'd0, 1'b0}},
      '{ROW_FILL,  3'd0, 16'h8000, 1'b0, '{64'd0, 1'b0}},
      '{ROW_ARG,   3'd0, 16'h0000, 1'b1, '{-64'sd32768, 1'b0}},
      '{ROW_ARG,   3'd0, 16'h0001, 1'b1, '{-64'sd262144, 1'b0}},
      '{ROW_ARG,   3'd0, 16'h8000, 1'b0, '{64'd0, 1'b0}},
      '{ROW_ARG,   3'd0, 16'h7FFF, 1'b0, '{64'd0, 1'b0}},
      '{ROW_FILL,  3'd0, 16'h0000, 1'b0, '{64'd0, 1'b0}},
      '{ROW_WRITE, 3'd7, 16'h0001, 1'b0, '{64'd0, 1'b0}},
      '{ROW_ARG,   3'd0, 16'h8000, 1'b0, '{64'd0, 1'b0}},
      '{ROW_ARG,   3'd0, 16'h0002, 1'b1, '{64'sd128, 1'b0}},
      '{ROW_WRITE, 3'd0, 16'hFFFF, 1'b0, '{64'd0, 1'b0}},
      '{ROW_ARG,   3'd0, 16'hFFFF, 1'b1, '{-64'sd2, 1'b0}},
      '{ROW_ARG,   3'd0, 16'h0000, 1'b1, '{-64'sd1, 1'b0}}
    };
    coef_q = HPE_COEF_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[r]) begin
      case (dir_tbl[r].kind)
        ROW_ARG: begin
          send_arg(dir_tbl[r].val,
                   dir_tbl[r].known ? dir_tbl[r].res : eval_poly(dir_tbl[r].val));
        end
        ROW_WRITE: begin
          write_reg(dir_tbl[r].idx, dir_tbl[r].val);
        end
        default: begin
          for (int k = 0; k < HPE_REG_COUNT; k++) write_reg(HPE_IDX_W'(k), dir_tbl[r].val);
        end
      endcase
    end

    for (int chunk = 0; chunk < RAND_CHUNKS; chunk++) begin
      mode = chunk % 4;
      deg = $urandom_range(1, HPE_NUM_COEFFS - 1);
      for (int k = 0; k < HPE_REG_COUNT; k++) begin
        case (mode)
          0: new_c = 16'($urandom());
          1: new_c = 16'(int'($urandom_range(0, 16)) - 8);
          2: new_c = (k > deg) ? 16'h0000 : 16'($urandom());
          default: new_c = EDGE_VALS[$urandom_range(0, 4)];
        endcase
        write_reg(HPE_IDX_W'(k), new_c);
      end
      cur_phase = chunk / 3;
      send_idle = (cur_phase == 0) ? 34 : (cur_phase == 1) ? 86 : 0;
      recv_idle = (cur_phase == 0) ? 86 : (cur_phase == 1) ? 34 : 0;
      repeat (CHUNK_ITEMS) begin
        arg_v = rand_arg();
        send_arg(arg_v, eval_poly(arg_v));
      end
    end

    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (2 * LAT_CYC) @(posedge clk);
    if (mism_cnt == 0 && pending_q.size() == 0) begin
      $display("tb_horner_polynomial_evaluator: PASS");
    end else begin
      $display("tb_horner_polynomial_evaluator: FAIL");
    end
    $finish;
  end

endmodule
